// ----- design/dq_pkg.sv -----
// shared types and defaults for the double-ended queue
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH      = 16;
    localparam int DQ_DATA_WIDTH = 32;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int PORT_W   = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_CLEAR      = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ----- design/double_ended_queue.sv -----
// double-ended queue over a ring memory: top level
//
// A command is transferred when start is high and busy is low. In the cycle
// of the command transfer the pointers and count are updated and a push
// writes the ring memory. In the next cycle (busy high) both ends of the
// queue are read from the ring memory, whose read data is registered, so the
// result appears in the cycle after that with done high for exactly one
// cycle. A new command may be transferred in that same cycle. Results cannot
// be stalled: capture them when done is high. front_value and back_value are
// zero when the queue is empty.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DQ_DEPTH,
    parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dq_pkg::KIND_W-1:0]     kind,
    input  wire logic [dq_pkg::PORT_W-1:0]     entry_value,
    output logic                               done,
    output logic [dq_pkg::PORT_W-1:0]          front_value,
    output logic [dq_pkg::PORT_W-1:0]          back_value,
    output logic [$clog2(DEPTH+1)-1:0]         entry_count,
    output logic                               is_empty,
    output logic [dq_pkg::STATUS_W-1:0]        status
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_POS  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] rd_front_reg;
    logic [DATA_WIDTH-1:0] rd_back_reg;

    logic                  accept;
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      tail_addr;
    logic [CNT_W-1:0]      back_off;
    logic [SUM_W-1:0]      back_sum;
    logic [PTR_W-1:0]      back_addr;
    logic                  q_empty;
    logic                  q_full;

    assign busy    = (state_reg == ST_READ);
    assign accept  = start && !busy;
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == FULL_CNT);
    assign wr_data = DATA_WIDTH'(entry_value);

    // slot just past the back, used by push back
    always_comb
    begin
        tail_sum = SUM_W'(front_reg) + SUM_W'(count_reg);
        if (tail_sum >= DEPTH_SUM)
        begin
            tail_sum = tail_sum - DEPTH_SUM;
        end
        tail_addr = tail_sum[PTR_W-1:0];
    end

    // back entry position for the read cycle
    always_comb
    begin
        back_off = q_empty ? '0 : (count_reg - CNT_W'(1));
        back_sum = SUM_W'(front_reg) + SUM_W'(back_off);
        if (back_sum >= DEPTH_SUM)
        begin
            back_sum = back_sum - DEPTH_SUM;
        end
        back_addr = back_sum[PTR_W-1:0];
    end

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_addr;
        if (accept)
        begin
            status_next = STATUS_OK;
            case (kind)
                KIND_PUSH_FRONT:
                begin
                    if (q_full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        front_next = (front_reg == '0) ? LAST_POS : (front_reg - PTR_W'(1));
                        wr_en      = 1'b1;
                        wr_addr    = front_next;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_PUSH_BACK:
                begin
                    if (q_full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (q_empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        front_next = (front_reg == LAST_POS) ? '0 : (front_reg + PTR_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                KIND_POP_BACK:
                begin
                    if (q_empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    front_next = front_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                state_next = accept ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = accept ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // ring memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (state_reg == ST_READ)
        begin
            rd_front_reg <= ring_mem[front_reg];
            rd_back_reg  <= ring_mem[back_addr];
        end
    end

    assign done        = (state_reg == ST_OUT);
    assign is_empty    = q_empty;
    assign entry_count = count_reg;
    assign status      = status_reg;
    assign front_value = q_empty ? '0 : PORT_W'(rd_front_reg);
    assign back_value  = q_empty ? '0 : PORT_W'(rd_back_reg);

endmodule

`default_nettype wire
